// ===== hdl/block_mean_variance_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the block mean and variance unit
// Each macro expands to a clocked concurrent assertion in simulation and to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BLOCK_MEAN_VARIANCE_UNIT_ASSERT_SVH
`define BLOCK_MEAN_VARIANCE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BMV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BMV_ASSERT_NEXT(label, cond, prop, msg) \
    `BMV_ASSERT(label, (cond) |=> (prop), msg)
`else
`define BMV_ASSERT(label, prop, msg)
`define BMV_ASSERT_NEXT(label, cond, prop, msg)
`endif
`endif

// ===== hdl/bmv_pkg.sv =====
// ----------------------------------------------------------------------------
// bmv_pkg
// Field widths, register indexes and the divider state type of the block
// mean and variance unit.
// ----------------------------------------------------------------------------
package bmv_pkg;

    localparam int SIZE_W      = 10;   // image size registers
    localparam int SIZE_RESET  = 512;  // reset image size before clamping
    localparam int PIXEL_W     = 8;
    localparam int PIXEL_MAX   = 2 ** PIXEL_W - 1;
    localparam int FRAC_W      = 8;    // fraction bits of mean and variance
    localparam int MEAN_W      = 16;
    localparam int VAR_W       = 22;
    localparam int TILE_IDX_W  = 5;
    localparam int PIXELS_W    = 9;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 1'd1;

    typedef enum logic [4:0] {
        DV_IDLE = 5'b00001,
        DV_MUL  = 5'b00010,
        DV_SUB  = 5'b00100,
        DV_DIV  = 5'b01000,
        DV_OUT  = 5'b10000
    } dv_state_t;

endpackage

// ===== hdl/block_mean_variance_unit.sv =====
// ----------------------------------------------------------------------------
// block_mean_variance_unit
// Tile-wise mean and population variance of a raster-order grayscale image,
// with per-tile-column running sums held in a synchronous memory.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// pixel     in         in_valid / in_ready   pixel
// result    out        out_valid / out_ready tile_row, tile_col, tile_pixels,
//                                            mean_q8, variance_q8, image_done
// config    in         cfg_we                cfg_index, cfg_data
//
// A pixel that does not close a tile streams through a read-modify-write of the
// sums memory at one pixel per cycle while in_ready is high, with the last
// write forwarded to the next read of the same tile column. A pixel that
// closes a tile holds in_ready low through the accumulate cycle, one multiply
// stage, one subtract and 22 restoring division steps in the shared divider,
// then the hand-over to the output register. A stalled result only stalls the
// input once the divider has a second tile finished. Reset clears the control
// state; the memory needs no clearing since the first pixel of a tile loads
// its entry.
// ----------------------------------------------------------------------------
`include "block_mean_variance_unit_assert.svh"

module block_mean_variance_unit #(
    parameter int TILE_ROWS = 16,
    parameter int TILE_COLS = 16,
    parameter int MAX_COLS  = 512,
    parameter int MAX_ROWS  = 512
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bmv_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bmv_pkg::SIZE_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [bmv_pkg::PIXEL_W-1:0]         pixel,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [bmv_pkg::TILE_IDX_W-1:0]      tile_row,
    output logic [bmv_pkg::TILE_IDX_W-1:0]      tile_col,
    output logic [bmv_pkg::PIXELS_W-1:0]        tile_pixels,
    output logic [bmv_pkg::MEAN_W-1:0]          mean_q8,
    output logic [bmv_pkg::VAR_W-1:0]           variance_q8,
    output logic                                image_done
);

    localparam int SIZE_W    = bmv_pkg::SIZE_W;
    localparam int PIXEL_W   = bmv_pkg::PIXEL_W;
    localparam int FRAC_W    = bmv_pkg::FRAC_W;
    localparam int MEAN_W    = bmv_pkg::MEAN_W;
    localparam int VAR_W     = bmv_pkg::VAR_W;
    localparam int SIZE_MAX  = 2 ** SIZE_W - 1;
    localparam int ROW_LIM   = (MAX_ROWS > SIZE_MAX) ? SIZE_MAX : MAX_ROWS;
    localparam int COL_LIM   = (MAX_COLS > SIZE_MAX) ? SIZE_MAX : MAX_COLS;
    localparam int RST_ROWS  = (ROW_LIM < bmv_pkg::SIZE_RESET) ? ROW_LIM : bmv_pkg::SIZE_RESET;
    localparam int RST_COLS  = (COL_LIM < bmv_pkg::SIZE_RESET) ? COL_LIM : bmv_pkg::SIZE_RESET;
    localparam int ROW_W     = $clog2(ROW_LIM);
    localparam int COL_W     = $clog2(COL_LIM);
    localparam int ROW_SLOTS = (ROW_LIM + TILE_ROWS - 1) / TILE_ROWS;
    localparam int COL_SLOTS = (COL_LIM + TILE_COLS - 1) / TILE_COLS;
    localparam int TR_W      = (ROW_SLOTS > 1) ? $clog2(ROW_SLOTS) : 1;
    localparam int TC_W      = (COL_SLOTS > 1) ? $clog2(COL_SLOTS) : 1;
    localparam int LR_W      = $clog2(TILE_ROWS);
    localparam int LC_W      = $clog2(TILE_COLS);
    localparam int PW        = LR_W + LC_W + 2;
    localparam int NMAX      = TILE_ROWS * TILE_COLS;
    localparam int N_W       = $clog2(NMAX + 1);
    localparam int SUM_W     = $clog2(NMAX * bmv_pkg::PIXEL_MAX + 1);
    localparam int SQ_W      = $clog2(NMAX * bmv_pkg::PIXEL_MAX * bmv_pkg::PIXEL_MAX + 1);
    localparam int NUM_W     = N_W + SQ_W;
    localparam int MEM_W     = SUM_W + SQ_W;
    localparam int CNT_W     = $clog2(VAR_W);

    localparam logic [SIZE_W-1:0] ROW_LIM_SZ  = SIZE_W'(ROW_LIM);
    localparam logic [SIZE_W-1:0] COL_LIM_SZ  = SIZE_W'(COL_LIM);
    localparam logic [LR_W-1:0]   LR_LAST     = LR_W'(TILE_ROWS - 1);
    localparam logic [LC_W-1:0]   LC_LAST     = LC_W'(TILE_COLS - 1);
    localparam logic [CNT_W-1:0]  CNT_START   = CNT_W'(VAR_W - 1);
    localparam logic [CNT_W-1:0]  CNT_MEAN    = CNT_W'(MEAN_W);

    function automatic logic [SIZE_W-1:0] clamp_size(
        input logic [SIZE_W-1:0] v,
        input logic [SIZE_W-1:0] lim
    );
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = SIZE_W'(1);
        end
        else if (v > lim)
        begin
            r = lim;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Size registers and raster position
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0] rows_reg;
    logic [SIZE_W-1:0] cols_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_reg;
    logic [LR_W-1:0]   lr_reg;
    logic [LC_W-1:0]   lc_reg;
    logic [TR_W-1:0]   tr_reg;
    logic [TC_W-1:0]   tc_reg;

    logic              in_fire;
    logic              row_end;
    logic              last_row;
    logic              tile_col_end;
    logic              tile_row_end;
    logic              tile_close;
    logic              frame_end;
    logic              tile_first;
    logic [LR_W:0]     tile_h;
    logic [LC_W:0]     tile_w;
    logic [PW-1:0]     tile_prod;
    logic [N_W-1:0]    tile_n;

    bmv_pkg::dv_state_t dv_state_reg;

    logic              s1_valid_reg;
    logic              s1_close_reg;

    assign in_ready = (dv_state_reg == bmv_pkg::DV_IDLE) && !(s1_valid_reg && s1_close_reg);
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        row_end      = (SIZE_W'(col_reg) == cols_reg - SIZE_W'(1));
        last_row     = (SIZE_W'(row_reg) == rows_reg - SIZE_W'(1));
        tile_col_end = (lc_reg == LC_LAST);
        tile_row_end = (lr_reg == LR_LAST);
        tile_close   = (tile_col_end || row_end) && (tile_row_end || last_row);
        frame_end    = row_end && last_row;
        tile_first   = (lr_reg == '0) && (lc_reg == '0);
        // At a tile close the clipped height and width are the local offsets plus one.
        tile_h       = {1'b0, lr_reg} + (LR_W + 1)'(1);
        tile_w       = {1'b0, lc_reg} + (LC_W + 1)'(1);
        tile_prod    = PW'(tile_h) * PW'(tile_w);
        tile_n       = N_W'(tile_prod);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= SIZE_W'(RST_ROWS);
            cols_reg <= SIZE_W'(RST_COLS);
            row_reg  <= '0;
            col_reg  <= '0;
            lr_reg   <= '0;
            lc_reg   <= '0;
            tr_reg   <= '0;
            tc_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bmv_pkg::REG_IMAGE_ROWS: rows_reg <= clamp_size(cfg_data, ROW_LIM_SZ);
                bmv_pkg::REG_IMAGE_COLS: cols_reg <= clamp_size(cfg_data, COL_LIM_SZ);
                default: ;
            endcase
            row_reg <= '0;
            col_reg <= '0;
            lr_reg  <= '0;
            lc_reg  <= '0;
            tr_reg  <= '0;
            tc_reg  <= '0;
        end
        else if (in_fire)
        begin
            if (row_end)
            begin
                col_reg <= '0;
                lc_reg  <= '0;
                tc_reg  <= '0;
                if (last_row)
                begin
                    row_reg <= '0;
                    lr_reg  <= '0;
                    tr_reg  <= '0;
                end
                else
                begin
                    row_reg <= row_reg + ROW_W'(1);
                    if (tile_row_end)
                    begin
                        lr_reg <= '0;
                        tr_reg <= tr_reg + TR_W'(1);
                    end
                    else
                    begin
                        lr_reg <= lr_reg + LR_W'(1);
                    end
                end
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
                if (tile_col_end)
                begin
                    lc_reg <= '0;
                    tc_reg <= tc_reg + TC_W'(1);
                end
                else
                begin
                    lc_reg <= lc_reg + LC_W'(1);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Accumulate stage: read at accept, modify and write back in the next cycle
    // ------------------------------------------------------------------
    logic [MEM_W-1:0]   sums_mem [0:COL_SLOTS-1];
    logic [MEM_W-1:0]   rd_data_reg;

    logic [PIXEL_W-1:0] s1_pix_reg;
    logic [TC_W-1:0]    s1_addr_reg;
    logic               s1_first_reg;
    logic               s1_done_reg;
    logic [TR_W-1:0]    s1_tr_reg;
    logic [N_W-1:0]     s1_n_reg;

    logic               fwd_valid_reg;
    logic [TC_W-1:0]    fwd_addr_reg;
    logic [SUM_W-1:0]   fwd_sum_reg;
    logic [SQ_W-1:0]    fwd_sq_reg;

    logic                 fwd_hit;
    logic [SUM_W-1:0]     base_sum;
    logic [SQ_W-1:0]      base_sq;
    logic [2*PIXEL_W-1:0] pix_sq;
    logic [SUM_W-1:0]     sum_new;
    logic [SQ_W-1:0]      sq_new;
    logic                 dv_load;

    always_comb
    begin
        fwd_hit = fwd_valid_reg && (fwd_addr_reg == s1_addr_reg);
        if (s1_first_reg)
        begin
            base_sum = '0;
            base_sq  = '0;
        end
        else if (fwd_hit)
        begin
            base_sum = fwd_sum_reg;
            base_sq  = fwd_sq_reg;
        end
        else
        begin
            base_sum = rd_data_reg[MEM_W-1:SQ_W];
            base_sq  = rd_data_reg[SQ_W-1:0];
        end
        pix_sq  = (2 * PIXEL_W)'(s1_pix_reg) * (2 * PIXEL_W)'(s1_pix_reg);
        sum_new = base_sum + SUM_W'(s1_pix_reg);
        sq_new  = base_sq + SQ_W'(pix_sq);
        dv_load = s1_valid_reg && s1_close_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            sums_mem[s1_addr_reg] <= {sum_new, sq_new};
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rd_data_reg <= sums_mem[tc_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_close_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_fire;
            s1_close_reg <= in_fire && tile_close;
            if (s1_valid_reg)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pix_reg   <= pixel;
            s1_addr_reg  <= tc_reg;
            s1_first_reg <= tile_first;
            s1_done_reg  <= frame_end;
            s1_tr_reg    <= tr_reg;
            s1_n_reg     <= tile_n;
        end
        if (s1_valid_reg)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_sum_reg  <= sum_new;
            fwd_sq_reg   <= sq_new;
        end
    end

    // ------------------------------------------------------------------
    // Tile statistics: products, numerator, then restoring division that
    // produces the mean and variance quotients together.
    // ------------------------------------------------------------------
    logic [N_W-1:0]       dv_n_reg;
    logic [SUM_W-1:0]     dv_s_reg;
    logic [SQ_W-1:0]      dv_q_reg;
    logic [TR_W-1:0]      dv_tr_reg;
    logic [TC_W-1:0]      dv_tc_reg;
    logic                 dv_done_reg;
    logic [NUM_W-1:0]     nq_reg;
    logic [2*SUM_W-1:0]   ss_reg;
    logic [2*N_W-1:0]     nn_reg;
    logic [CNT_W-1:0]     dv_cnt_reg;
    logic [N_W-1:0]       mr_reg;
    logic [MEAN_W-1:0]    mlow_reg;
    logic [MEAN_W-1:0]    mq_reg;
    logic [2*N_W-1:0]     vr_reg;
    logic [VAR_W-1:0]     vlow_reg;
    logic [VAR_W-1:0]     vq_reg;

    logic [NUM_W-1:0]     num;
    logic [2*N_W:0]       vtry;
    logic                 vge;
    logic [2*N_W-1:0]     vr_next;
    logic [N_W:0]         mtry;
    logic                 mge;
    logic [N_W-1:0]       mr_next;
    logic                 mean_step;
    logic                 out_load;

    logic                 out_valid_reg;

    always_comb
    begin
        num       = nq_reg - NUM_W'(ss_reg);
        vtry      = {vr_reg, vlow_reg[VAR_W-1]};
        vge       = (vtry >= {1'b0, nn_reg});
        vr_next   = vge ? (2 * N_W)'(vtry - {1'b0, nn_reg}) : vtry[2*N_W-1:0];
        mtry      = {mr_reg, mlow_reg[MEAN_W-1]};
        mge       = (mtry >= {1'b0, dv_n_reg});
        mr_next   = mge ? N_W'(mtry - {1'b0, dv_n_reg}) : mtry[N_W-1:0];
        mean_step = (dv_cnt_reg < CNT_MEAN);
        out_load  = (dv_state_reg == bmv_pkg::DV_OUT) && (!out_valid_reg || out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_state_reg <= bmv_pkg::DV_IDLE;
            dv_cnt_reg   <= '0;
        end
        else
        begin
            unique case (dv_state_reg)
                bmv_pkg::DV_IDLE:
                begin
                    if (dv_load)
                    begin
                        dv_state_reg <= bmv_pkg::DV_MUL;
                    end
                end
                bmv_pkg::DV_MUL:
                begin
                    dv_state_reg <= bmv_pkg::DV_SUB;
                end
                bmv_pkg::DV_SUB:
                begin
                    dv_cnt_reg   <= CNT_START;
                    dv_state_reg <= bmv_pkg::DV_DIV;
                end
                bmv_pkg::DV_DIV:
                begin
                    dv_cnt_reg <= dv_cnt_reg - CNT_W'(1);
                    if (dv_cnt_reg == '0)
                    begin
                        dv_state_reg <= bmv_pkg::DV_OUT;
                    end
                end
                bmv_pkg::DV_OUT:
                begin
                    if (out_load)
                    begin
                        dv_state_reg <= bmv_pkg::DV_IDLE;
                    end
                end
                default:
                begin
                    dv_state_reg <= bmv_pkg::DV_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (dv_load && (dv_state_reg == bmv_pkg::DV_IDLE))
        begin
            dv_n_reg    <= s1_n_reg;
            dv_s_reg    <= sum_new;
            dv_q_reg    <= sq_new;
            dv_tr_reg   <= s1_tr_reg;
            dv_tc_reg   <= s1_addr_reg;
            dv_done_reg <= s1_done_reg;
        end
        if (dv_state_reg == bmv_pkg::DV_MUL)
        begin
            nq_reg <= NUM_W'(dv_n_reg) * NUM_W'(dv_q_reg);
            ss_reg <= (2 * SUM_W)'(dv_s_reg) * (2 * SUM_W)'(dv_s_reg);
            nn_reg <= (2 * N_W)'(dv_n_reg) * (2 * N_W)'(dv_n_reg);
        end
        if (dv_state_reg == bmv_pkg::DV_SUB)
        begin
            // The quotients are known to fit their widths, so the upper part
            // of each dividend is already below the divisor.
            vr_reg   <= (2 * N_W)'(num >> (VAR_W - FRAC_W));
            vlow_reg <= {num[VAR_W-FRAC_W-1:0], FRAC_W'(0)};
            mr_reg   <= N_W'(dv_s_reg >> (MEAN_W - FRAC_W));
            mlow_reg <= {dv_s_reg[MEAN_W-FRAC_W-1:0], FRAC_W'(0)};
        end
        if (dv_state_reg == bmv_pkg::DV_DIV)
        begin
            vr_reg   <= vr_next;
            vlow_reg <= {vlow_reg[VAR_W-2:0], 1'b0};
            vq_reg   <= {vq_reg[VAR_W-2:0], vge};
            if (mean_step)
            begin
                mr_reg   <= mr_next;
                mlow_reg <= {mlow_reg[MEAN_W-2:0], 1'b0};
                mq_reg   <= {mq_reg[MEAN_W-2:0], mge};
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [bmv_pkg::TILE_IDX_W-1:0] tile_row_reg;
    logic [bmv_pkg::TILE_IDX_W-1:0] tile_col_reg;
    logic [bmv_pkg::PIXELS_W-1:0]   tile_pixels_reg;
    logic [MEAN_W-1:0]              mean_q8_reg;
    logic [VAR_W-1:0]               variance_q8_reg;
    logic                           image_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            tile_row_reg    <= bmv_pkg::TILE_IDX_W'(dv_tr_reg);
            tile_col_reg    <= bmv_pkg::TILE_IDX_W'(dv_tc_reg);
            tile_pixels_reg <= bmv_pkg::PIXELS_W'(dv_n_reg);
            mean_q8_reg     <= mq_reg;
            variance_q8_reg <= vq_reg;
            image_done_reg  <= dv_done_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign tile_row    = tile_row_reg;
    assign tile_col    = tile_col_reg;
    assign tile_pixels = tile_pixels_reg;
    assign mean_q8     = mean_q8_reg;
    assign variance_q8 = variance_q8_reg;
    assign image_done  = image_done_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `BMV_ASSERT(a_close_finds_idle,
        (s1_valid_reg && s1_close_reg) |-> (dv_state_reg == bmv_pkg::DV_IDLE),
        "tile close while divider busy")
    `BMV_ASSERT(a_out_from_divider,
        $rose(out_valid_reg) |-> $past(dv_state_reg == bmv_pkg::DV_OUT),
        "result appeared without divider")
    `BMV_ASSERT(a_var_rem_bound,
        (dv_state_reg == bmv_pkg::DV_DIV) |-> (vr_reg < nn_reg),
        "variance remainder not below divisor")
    `BMV_ASSERT(a_mean_rem_bound,
        (dv_state_reg == bmv_pkg::DV_DIV) |-> (mr_reg < dv_n_reg),
        "mean remainder not below divisor")
    `BMV_ASSERT_NEXT(a_div_count,
        (dv_state_reg == bmv_pkg::DV_DIV) && (dv_cnt_reg != '0),
        (dv_state_reg == bmv_pkg::DV_DIV) && (dv_cnt_reg == $past(dv_cnt_reg) - CNT_W'(1)),
        "division step count broken")

endmodule

// ===== tb/block_mean_variance_unit_test.sv =====
// ----------------------------------------------------------------------------
// block_mean_variance_unit_test
// Streams raster-order pixel images of many sizes through the tile mean and
// variance unit. A behavioral tile accumulator predicts every finished tile,
// and each result transaction is compared field by field with the oldest
// prediction. The run covers random input gaps, random output stalls and one
// long output hold-off.
// ----------------------------------------------------------------------------
module block_mean_variance_unit_test;

    localparam int TILE_ROWS   = 16;
    localparam int TILE_COLS   = 16;
    localparam int MAX_COLS    = 512;
    localparam int MAX_ROWS    = 512;
    localparam int TILE_SLOTS  = (MAX_COLS + TILE_COLS - 1) / TILE_COLS;
    localparam int SETTLE      = 40;      // cycles for a tile still in the divider
    localparam int RUN_LIMIT   = 300000;
    localparam int RANDOM_PIXELS = 800;

    typedef struct packed {
        logic [bmv_pkg::TILE_IDX_W-1:0] tile_row;
        logic [bmv_pkg::TILE_IDX_W-1:0] tile_col;
        logic [bmv_pkg::PIXELS_W-1:0]   tile_pixels;
        logic [bmv_pkg::MEAN_W-1:0]     mean_q8;
        logic [bmv_pkg::VAR_W-1:0]      variance_q8;
        logic                           image_done;
    } tile_stat_t;

    typedef enum int {
        PIX_UNIFORM,
        PIX_FLAT,
        PIX_NOISY,
        PIX_EXTREME
    } pixel_mode_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [bmv_pkg::CFG_IDX_W-1:0]   cfg_index = bmv_pkg::REG_IMAGE_ROWS;
    logic [bmv_pkg::SIZE_W-1:0]      cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic [bmv_pkg::PIXEL_W-1:0]     pixel = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [bmv_pkg::TILE_IDX_W-1:0]  tile_row;
    logic [bmv_pkg::TILE_IDX_W-1:0]  tile_col;
    logic [bmv_pkg::PIXELS_W-1:0]    tile_pixels;
    logic [bmv_pkg::MEAN_W-1:0]      mean_q8;
    logic [bmv_pkg::VAR_W-1:0]       variance_q8;
    logic                            image_done;

    // Accumulator state of the prediction.
    longint unsigned col_sum [TILE_SLOTS];
    longint unsigned col_sq_sum [TILE_SLOTS];
    int unsigned     row_pos = 0;
    int unsigned     col_pos = 0;
    int unsigned     image_rows = MAX_ROWS;
    int unsigned     image_cols = MAX_COLS;

    tile_stat_t expected_tiles[$];

    logic steady = 1'b0;
    int   hold_req = 0;
    int   hold_left = 0;
    int   failures = 0;
    int   pixels_sent = 0;
    int   results_seen = 0;
    int   frames_done = 0;
    int   cycle_count = 0;

    block_mean_variance_unit #(
        .TILE_ROWS (TILE_ROWS),
        .TILE_COLS (TILE_COLS),
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel       (pixel),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .tile_row    (tile_row),
        .tile_col    (tile_col),
        .tile_pixels (tile_pixels),
        .mean_q8     (mean_q8),
        .variance_q8 (variance_q8),
        .image_done  (image_done)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d tiles outstanding.",
                     cycle_count, expected_tiles.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int unsigned clamp_size(input logic [bmv_pkg::SIZE_W-1:0] value,
                                               input int unsigned limit);
        if (value == 0)
            return 1;
        if (value > limit)
            return limit;
        return value;
    endfunction

    // Adds one accepted pixel to its tile column and queues the tile's
    // statistics when this pixel closes the tile.
    function automatic void accumulate_pixel(input logic [bmv_pkg::PIXEL_W-1:0] value);
        int unsigned     r, c, tr, tc, lr, lc, h, w;
        longint unsigned v, n, s, q;
        tile_stat_t      stat;
        if (row_pos >= image_rows || col_pos >= image_cols)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        r  = row_pos;
        c  = col_pos;
        tr = r / TILE_ROWS;
        tc = c / TILE_COLS;
        lr = r % TILE_ROWS;
        lc = c % TILE_COLS;
        v  = value;
        if (lr == 0 && lc == 0)
        begin
            col_sum[tc]    = v;
            col_sq_sum[tc] = v * v;
        end
        else
        begin
            col_sum[tc]    += v;
            col_sq_sum[tc] += v * v;
        end
        if ((lc == TILE_COLS - 1 || c == image_cols - 1) &&
            (lr == TILE_ROWS - 1 || r == image_rows - 1))
        begin
            h = image_rows - tr * TILE_ROWS;
            if (h > TILE_ROWS)
                h = TILE_ROWS;
            w = image_cols - tc * TILE_COLS;
            if (w > TILE_COLS)
                w = TILE_COLS;
            n = h * w;
            s = col_sum[tc];
            q = col_sq_sum[tc];
            stat.tile_row    = bmv_pkg::TILE_IDX_W'(tr);
            stat.tile_col    = bmv_pkg::TILE_IDX_W'(tc);
            stat.tile_pixels = bmv_pkg::PIXELS_W'(n);
            stat.mean_q8     = bmv_pkg::MEAN_W'((s << 8) / n);
            stat.variance_q8 = bmv_pkg::VAR_W'(((n * q - s * s) << 8) / (n * n));
            stat.image_done  = (r == image_rows - 1) && (c == image_cols - 1);
            expected_tiles.push_back(stat);
        end
        c++;
        if (c >= image_cols)
        begin
            c = 0;
            r++;
            if (r >= image_rows)
                r = 0;
        end
        row_pos = r;
        col_pos = c;
        pixels_sent++;
    endfunction

    // Output side: random stalls unless steady is set, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_req - 1;
            hold_req  <= 0;
        end
        else
            out_ready <= steady || ($urandom_range(99) >= 8);
    end

    always @(posedge clk)
    begin : check_results
        tile_stat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_tiles.size() == 0)
            begin
                $error("result transaction with no tile pending: row %0d col %0d",
                       tile_row, tile_col);
                failures++;
            end
            else
            begin
                want = expected_tiles.pop_front();
                results_seen++;
                if (image_done)
                    frames_done++;
                if (tile_row !== want.tile_row)
                begin
                    $error("tile_row: expected %0d, got %0d", want.tile_row, tile_row);
                    failures++;
                end
                if (tile_col !== want.tile_col)
                begin
                    $error("tile_col: expected %0d, got %0d", want.tile_col, tile_col);
                    failures++;
                end
                if (tile_pixels !== want.tile_pixels)
                begin
                    $error("tile_pixels: expected %0d, got %0d",
                           want.tile_pixels, tile_pixels);
                    failures++;
                end
                if (mean_q8 !== want.mean_q8)
                begin
                    $error("mean_q8: expected %0d, got %0d", want.mean_q8, mean_q8);
                    failures++;
                end
                if (variance_q8 !== want.variance_q8)
                begin
                    $error("variance_q8: expected %0d, got %0d",
                           want.variance_q8, variance_q8);
                    failures++;
                end
                if (image_done !== want.image_done)
                begin
                    $error("image_done: expected %0d, got %0d",
                           want.image_done, image_done);
                    failures++;
                end
            end
        end
    end

    // Offers one pixel, with a random gap first unless steady is set, and holds it until accepted.
    // Valid stays high afterward so that back-to-back pixels never toggle it.
    task automatic send_pixel(input logic [bmv_pkg::PIXEL_W-1:0] value);
        if (!steady)
        begin
            while ($urandom_range(99) < 8)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        pixel    <= value;
        do
            @(posedge clk);
        while (!in_ready);
        accumulate_pixel(value);
    endtask

    // Stops the input and waits until every pending tile has come out and
    // the divider has had time to finish any work in flight.
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_tiles.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_sizes(input logic [bmv_pkg::SIZE_W-1:0] rows,
                               input logic [bmv_pkg::SIZE_W-1:0] cols);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= bmv_pkg::REG_IMAGE_ROWS;
        cfg_data  <= rows;
        @(posedge clk);
        image_rows = clamp_size(rows, MAX_ROWS);
        row_pos    = 0;
        col_pos    = 0;
        cfg_index <= bmv_pkg::REG_IMAGE_COLS;
        cfg_data  <= cols;
        @(posedge clk);
        image_cols = clamp_size(cols, MAX_COLS);
        row_pos    = 0;
        col_pos    = 0;
        cfg_we    <= 1'b0;
    endtask

    task automatic send_frame(input int count, input pixel_mode_t mode);
        int base;
        int value;
        base = $urandom_range(255);
        for (int i = 0; i < count; i++)
        begin
            case (mode)
                PIX_FLAT:    value = base;
                PIX_NOISY:   value = base + int'($urandom_range(15)) - 8;
                PIX_EXTREME: value = $urandom_range(1) ? bmv_pkg::PIXEL_MAX : 0;
                default:     value = $urandom_range(bmv_pkg::PIXEL_MAX);
            endcase
            if (value < 0)
                value = 0;
            if (value > bmv_pkg::PIXEL_MAX)
                value = bmv_pkg::PIXEL_MAX;
            send_pixel(bmv_pkg::PIXEL_W'(value));
        end
    endtask

    // Single-pixel images, the largest mean and variance, a zero size taken
    // as one, and a saturated width with a frame cut short by a restart.
    task automatic test_edge_cases();
        write_sizes(0, 1);
        send_pixel(bmv_pkg::PIXEL_W'(bmv_pkg::PIXEL_MAX));
        send_pixel('0);
        write_sizes(1, 2);
        send_pixel('0);
        send_pixel(bmv_pkg::PIXEL_W'(bmv_pkg::PIXEL_MAX));
        send_pixel(bmv_pkg::PIXEL_W'(bmv_pkg::PIXEL_MAX));
        send_pixel(bmv_pkg::PIXEL_W'(bmv_pkg::PIXEL_MAX));
        write_sizes(1, 10'h3FF);
        for (int i = 0; i < TILE_COLS + 1; i++)
            send_pixel(bmv_pkg::PIXEL_W'(i * 15));
    endtask

    // A full 512-row single-column image, streamed with no random input gaps or
    // output stalls, so that every tile row index and the end of the image are reached.
    task automatic test_saturated_rows();
        write_sizes(10'h3FF, 1);
        steady = 1'b1;
        send_frame(MAX_ROWS, PIX_UNIFORM);
        drain();
        steady = 1'b0;
    endtask

    // Every pixel closes a tile while the output is held off, so results
    // back up and the input has to stall.
    task automatic test_output_stall();
        write_sizes(1, 1);
        hold_req <= 500;
        send_frame(24, PIX_UNIFORM);
    endtask

    task automatic test_random_frames();
        int          goal;
        int          dims [2];
        int          frame;
        pixel_mode_t mode;
        goal = pixels_sent + RANDOM_PIXELS;
        while (pixels_sent < goal)
        begin
            foreach (dims[k])
            begin
                case ($urandom_range(9))
                    0:       dims[k] = 0;
                    1:       dims[k] = TILE_ROWS;
                    2:       dims[k] = TILE_ROWS + 1;
                    3:       dims[k] = 1;
                    default: dims[k] = $urandom_range(2, 24);
                endcase
            end
            write_sizes(bmv_pkg::SIZE_W'(dims[0]), bmv_pkg::SIZE_W'(dims[1]));
            frame = image_rows * image_cols;
            mode  = pixel_mode_t'($urandom_range(PIX_EXTREME));
            // Some frames are cut short; the next size write restarts them.
            if ($urandom_range(4) == 0)
                send_frame($urandom_range(1, frame), mode);
            else if (frame > 300)
                send_frame(frame, mode);
            else
                send_frame(frame * $urandom_range(1, 2), mode);
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_edge_cases();
        test_saturated_rows();
        test_output_stall();
        test_random_frames();
        drain();
        $display("Checked %0d tile results from %0d pixels; %0d images ran to the end.",
                 results_seen, pixels_sent, frames_done);
        $display("Sizes ranged from single pixels through clipped tiles to 512 rows.");
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
